### rtl/stk_pkg.sv
// Shared types and constants for the stack processor data stack.
// No dependencies; used by stk_shift and stack_cpu_data_stack.
`timescale 1ns / 1ps
`default_nettype none

package stk_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WIDTH_DEF = 16;
    localparam int FIELD_W   = 16;
    localparam int MODE_W    = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_NOP      = 4'd0,
        MODE_ALU_BIN  = 4'd1,
        MODE_ALU_UN   = 4'd2,
        MODE_FETCH    = 4'd3,
        MODE_DUP      = 4'd4,
        MODE_OVER     = 4'd5,
        MODE_DROP     = 4'd6,
        MODE_SWAP     = 4'd7,
        MODE_ROT      = 4'd8,
        MODE_STORE    = 4'd9,
        MODE_ADDRESS  = 4'd10,
        MODE_CONSTANT = 4'd11,
        MODE_RFROM    = 4'd12
    } mode_t;

    typedef struct packed {
        logic  step;
        mode_t mode;
    } step_ctl_t;

endpackage

`default_nettype wire

### rtl/stack_cpu_data_stack.sv
// Top level of the stack processor data stack: request register, stack row, result register.
// Depends on stk_pkg and stk_shift.
`timescale 1ns / 1ps
`default_nettype none

// Takes one instruction request per clock and returns one result per request: the new top
// two stack entries and the top two from before the instruction. A request is registered on
// acceptance and applied to the stack row as the result register loads, so its result
// passes the request register and then the result register. The sustained rate is one
// request every cycle while results are taken, as the whole stack row updates at once. A
// result held by the receiver stalls the input once the request register is also full.
// The stack holds DEPTH words of WIDTH bits; port words are cut or zero-extended to WIDTH
// on the way in and to 16 bits on the way out. Entries below the bottom read as zero; a
// push at full depth loses the bottom word. Modes 13 to 15 leave the stack unchanged.
module stack_cpu_data_stack #(
    parameter int DEPTH = stk_pkg::DEPTH_DEF,
    parameter int WIDTH = stk_pkg::WIDTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [stk_pkg::MODE_W-1:0]  mode,
    input  wire logic [stk_pkg::FIELD_W-1:0] alu_result,
    input  wire logic [stk_pkg::FIELD_W-1:0] address_value,
    input  wire logic [stk_pkg::FIELD_W-1:0] return_top,
    input  wire logic [stk_pkg::FIELD_W-1:0] bus_value,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [stk_pkg::FIELD_W-1:0] new_top,
    output logic      [stk_pkg::FIELD_W-1:0] new_second,
    output logic      [stk_pkg::FIELD_W-1:0] old_top,
    output logic      [stk_pkg::FIELD_W-1:0] old_second
);

    localparam int FW = stk_pkg::FIELD_W;
    localparam int XW = FW + WIDTH;

    logic                req_valid_reg;
    stk_pkg::mode_t      mode_reg;
    logic [FW-1:0]       alu_reg;
    logic [FW-1:0]       adr_reg;
    logic [FW-1:0]       ret_reg;
    logic [FW-1:0]       bus_reg;

    logic                out_valid_reg;
    logic [FW-1:0]       new_top_reg;
    logic [FW-1:0]       new_second_reg;
    logic [FW-1:0]       old_top_reg;
    logic [FW-1:0]       old_second_reg;

    logic                advance;
    stk_pkg::step_ctl_t  ctl;

    logic [XW-1:0]       alu_x, adr_x, ret_x, bus_x;
    logic [WIDTH-1:0]    top_w, second_w, top_next_w, second_next_w;
    logic [XW-1:0]       top_x, second_x, top_next_x, second_next_x;

    assign advance  = req_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !req_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                req_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg <= stk_pkg::mode_t'(mode);
            alu_reg  <= alu_result;
            adr_reg  <= address_value;
            ret_reg  <= return_top;
            bus_reg  <= bus_value;
        end
        if (advance)
        begin
            new_top_reg    <= top_next_x[FW-1:0];
            new_second_reg <= second_next_x[FW-1:0];
            old_top_reg    <= top_x[FW-1:0];
            old_second_reg <= second_x[FW-1:0];
        end
    end

    // fit port words to the stack width
    assign alu_x = {{WIDTH{1'b0}}, alu_reg};
    assign adr_x = {{WIDTH{1'b0}}, adr_reg};
    assign ret_x = {{WIDTH{1'b0}}, ret_reg};
    assign bus_x = {{WIDTH{1'b0}}, bus_reg};

    assign top_x         = {{FW{1'b0}}, top_w};
    assign second_x      = {{FW{1'b0}}, second_w};
    assign top_next_x    = {{FW{1'b0}}, top_next_w};
    assign second_next_x = {{FW{1'b0}}, second_next_w};

    assign ctl.step = advance;
    assign ctl.mode = mode_reg;

    stk_shift #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_shift (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .alu_word    (alu_x[WIDTH-1:0]),
        .adr_word    (adr_x[WIDTH-1:0]),
        .ret_word    (ret_x[WIDTH-1:0]),
        .bus_word    (bus_x[WIDTH-1:0]),
        .top         (top_w),
        .second      (second_w),
        .top_next    (top_next_w),
        .second_next (second_next_w)
    );

    assign out_valid  = out_valid_reg;
    assign new_top    = new_top_reg;
    assign new_second = new_second_reg;
    assign old_top    = old_top_reg;
    assign old_second = old_second_reg;

endmodule

`default_nettype wire

### rtl/stk_shift.sv
// Row of stack registers that all shift together on a step, entry 0 on top.
// Depends on stk_pkg for the mode codes and the step control struct.
`timescale 1ns / 1ps
`default_nettype none

module stk_shift #(
    parameter int DEPTH = stk_pkg::DEPTH_DEF,
    parameter int WIDTH = stk_pkg::WIDTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire stk_pkg::step_ctl_t ctl,
    input  wire logic [WIDTH-1:0] alu_word,
    input  wire logic [WIDTH-1:0] adr_word,
    input  wire logic [WIDTH-1:0] ret_word,
    input  wire logic [WIDTH-1:0] bus_word,
    output logic      [WIDTH-1:0] top,
    output logic      [WIDTH-1:0] second,
    output logic      [WIDTH-1:0] top_next,
    output logic      [WIDTH-1:0] second_next
);

    logic [WIDTH-1:0] entry_reg  [DEPTH];
    logic [WIDTH-1:0] entry_next [DEPTH];
    logic [WIDTH-1:0] ext        [DEPTH+2];

    // entries past the bottom read as zero
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ext[i] = entry_reg[i];
        end
        ext[DEPTH]   = '0;
        ext[DEPTH+1] = '0;
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            entry_next[i] = entry_reg[i];
        end
        case (ctl.mode)
            stk_pkg::MODE_ALU_BIN, stk_pkg::MODE_DROP:
            begin
                entry_next[0] = (ctl.mode == stk_pkg::MODE_ALU_BIN) ? alu_word : ext[1];
                for (int i = 1; i < DEPTH; i++)
                begin
                    entry_next[i] = ext[i+1];
                end
            end
            stk_pkg::MODE_STORE:
            begin
                entry_next[0] = ext[2];
                for (int i = 1; i < DEPTH; i++)
                begin
                    entry_next[i] = ext[i+2];
                end
            end
            stk_pkg::MODE_ALU_UN:
            begin
                entry_next[0] = alu_word;
            end
            stk_pkg::MODE_FETCH:
            begin
                entry_next[0] = bus_word;
            end
            stk_pkg::MODE_DUP, stk_pkg::MODE_OVER, stk_pkg::MODE_ADDRESS,
            stk_pkg::MODE_CONSTANT, stk_pkg::MODE_RFROM:
            begin
                case (ctl.mode)
                    stk_pkg::MODE_DUP:      entry_next[0] = ext[0];
                    stk_pkg::MODE_OVER:     entry_next[0] = ext[1];
                    stk_pkg::MODE_ADDRESS:  entry_next[0] = adr_word;
                    stk_pkg::MODE_CONSTANT: entry_next[0] = bus_word;
                    default:                entry_next[0] = ret_word;
                endcase
                for (int i = 1; i < DEPTH; i++)
                begin
                    entry_next[i] = ext[i-1];
                end
            end
            stk_pkg::MODE_SWAP:
            begin
                entry_next[0] = ext[1];
                entry_next[1] = ext[0];
            end
            stk_pkg::MODE_ROT:
            begin
                entry_next[0] = ext[2];
                entry_next[1] = ext[0];
                entry_next[2] = ext[1];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                entry_reg[i] <= '0;
            end
        end
        else if (ctl.step)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                entry_reg[i] <= entry_next[i];
            end
        end
    end

    assign top         = entry_reg[0];
    assign second      = entry_reg[1];
    assign top_next    = entry_next[0];
    assign second_next = entry_next[1];

`ifndef ASSERT_OFF
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.step |=> ($stable(entry_reg[0]) && $stable(entry_reg[DEPTH-1])))
        else $error("stack changed without a step");

    a_push_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.step && ctl.mode == stk_pkg::MODE_DUP)
        |=> (entry_reg[1] == $past(entry_reg[0]) && entry_reg[0] == $past(entry_reg[0])))
        else $error("dup did not push the top");

    a_swap: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.step && ctl.mode == stk_pkg::MODE_SWAP)
        |=> (entry_reg[0] == $past(entry_reg[1]) && entry_reg[1] == $past(entry_reg[0])))
        else $error("swap did not exchange the top two");

    a_drop_bottom: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.step && (ctl.mode == stk_pkg::MODE_DROP || ctl.mode == stk_pkg::MODE_STORE))
        |=> entry_reg[DEPTH-1] == '0)
        else $error("pop did not clear the bottom entry");
`endif

endmodule

`default_nettype wire
